// ===== rtl/scfc_pkg.sv =====
`default_nettype none
package scfc_pkg;

	// Item operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_MOD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEW_MOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDENTIFY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAMP     = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [7:0] HEADER_RST   = 8'd255;
	localparam logic [7:0] EMPTY_RST    = 8'd0;
	localparam logic [7:0] NO_MOD_RST   = 8'd254;
	localparam logic [7:0] NEW_MOD_RST  = 8'd254;
	localparam logic [7:0] IDENTIFY_RST = 8'd252;
	localparam logic [7:0] SERVO_RST    = 8'd1;
	localparam logic [7:0] LAMP_RST     = 8'd2;

	// A reply of zero means the module has left the chain.
	localparam logic [7:0] ZERO_REPLY = 8'h00;

	// Depth of the command queue between front and back.
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] empty;
		logic [7:0] no_mod;
		logic [7:0] new_mod;
		logic [7:0] identify;
		logic [7:0] servo;
		logic [7:0] lamp;
	} cfg_t;

	typedef struct packed {
		logic       is_frame;
		logic [1:0] slot;
		logic [7:0] first;
		logic       wr_first;
		logic [7:0] second;
		logic       wr_second;
		logic [7:0] reply;
	} cmd_t;

	// Folded checksum: s += s >> 8; s += s << 4; keep bits 7:4, poll slot below.
	function automatic logic [7:0] fold_check(input logic [15:0] s, input logic [3:0] p);
		logic [15:0] t;
		logic [3:0]  hi;
		t  = s + {8'd0, s[15:8]};
		hi = t[7:4] + t[3:0];
		return {hi, p};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/scfc_front.sv =====
`default_nettype none
module scfc_front #(
	parameter int SLOTS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire scfc_pkg::cmd_t in_cmd,
	output logic               q_valid,
	output scfc_pkg::cmd_t     q_cmd,
	input  wire logic          q_pop
);
	import scfc_pkg::*;

	localparam int CW = $clog2(QDEPTH + 1);
	localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	cmd_t            mem_q [QDEPTH];
	logic [PTRW-1:0] wr_q;
	logic [PTRW-1:0] rd_q;
	logic [CW-1:0]   count_q;
	logic            keep;
	logic            push;
	logic            pop;

	// Writes that cannot change anything never enter the queue.
	assign keep = (in_cmd.is_frame == OP_FRAME) ||
		((32'(in_cmd.slot) < SLOTS) && (in_cmd.wr_first || in_cmd.wr_second));

	assign in_ready = (count_q != CW'(QDEPTH));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/scfc_back.sv =====
`default_nettype none
module scfc_back #(
	parameter int SLOTS = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire scfc_pkg::cfg_t cfg,
	input  wire logic           q_valid,
	input  wire scfc_pkg::cmd_t q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          line_byte,
	output logic                frame_end,
	output logic [1:0]          polled_slot,
	output logic                polled_connected,
	output logic [7:0]          polled_type,
	output logic [7:0]          polled_reading
);
	import scfc_pkg::*;

	localparam int PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW    = $clog2(SLOTS + 2);
	localparam int SUM_W = $clog2(SLOTS * 255 + 1);

	// Slot state.
	logic [7:0]    slot_byte_q [SLOTS];
	logic [7:0]    pend1_q     [SLOTS];
	logic [7:0]    pend2_q     [SLOTS];
	logic [SLOTS-1:0] conn_q;
	logic [7:0]    type_q      [SLOTS];
	logic [7:0]    read_q      [SLOTS];
	logic [PW-1:0] poll_q;

	// Frame sequencer.
	logic          busy_q;
	logic [BW-1:0] beat_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0]    snap_q [SLOTS];
	logic [PW-1:0] pol_slot_q;
	logic          pol_conn_q;
	logic [7:0]    pol_type_q;
	logic [7:0]    pol_read_q;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    line_q;
	logic          end_q;
	logic [PW-1:0] oslot_q;
	logic          oconn_q;
	logic [7:0]    otype_q;
	logic [7:0]    oread_q;

	logic          start;
	logic          wr;
	logic          adv;
	logic          last_beat;
	logic [PW-1:0] wr_idx;
	logic [PW+1:0] wr_ext;
	logic [PW+1:0] oslot_ext;
	logic [7:0]    drain_v [SLOTS];
	logic [7:0]    byte_d  [SLOTS];
	logic [7:0]    byte_n  [SLOTS];
	logic          c_p;
	logic          conn_n;
	logic [7:0]    type_n;
	logic [7:0]    read_n;
	logic [7:0]    reply;
	logic [PW-1:0] poll_n;

	assign start     = q_valid && (q_cmd.is_frame == OP_FRAME) && !busy_q;
	assign wr        = q_valid && (q_cmd.is_frame == OP_WRITE);
	assign q_pop     = start || wr;
	assign adv       = busy_q && (!out_valid_q || out_ready);
	assign last_beat = (beat_q == BW'(SLOTS + 1));
	assign reply     = q_cmd.reply;
	assign wr_ext    = (PW + 2)'(q_cmd.slot);
	assign wr_idx    = wr_ext[PW-1:0];
	assign poll_n    = (poll_q == PW'(SLOTS - 1)) ? '0 : poll_q + 1'b1;

	// Every connected slot drains one pending byte, the first before the second, when a frame starts.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			drain_v[i] = (pend1_q[i] != cfg.empty) ? pend1_q[i] : pend2_q[i];
			byte_d[i]  = (conn_q[i] && (drain_v[i] != cfg.empty)) ? drain_v[i]
				: slot_byte_q[i];
			byte_n[i]  = byte_d[i];
			if (PW'(i) == poll_q) begin
				if (reply == cfg.new_mod) begin
					byte_n[i] = cfg.identify;
				end
				if (reply == ZERO_REPLY) begin
					byte_n[i] = cfg.no_mod;
				end
			end
		end
	end

	// Reply handling for the polled slot.
	always_comb begin
		c_p    = conn_q[poll_q];
		conn_n = c_p;
		type_n = type_q[poll_q];
		read_n = read_q[poll_q];
		if (!c_p) begin
			if ((reply == cfg.servo) || (reply == cfg.lamp)) begin
				conn_n = 1'b1;
				type_n = reply;
			end
		end else begin
			read_n = reply;
		end
		if (reply == ZERO_REPLY) begin
			conn_n = 1'b0;
			type_n = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_byte_q[i] <= NO_MOD_RST;
				pend1_q[i]     <= EMPTY_RST;
				pend2_q[i]     <= EMPTY_RST;
				type_q[i]      <= 8'd0;
				read_q[i]      <= 8'd0;
			end
			conn_q      <= '0;
			poll_q      <= '0;
			busy_q      <= 1'b0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr) begin
				if (q_cmd.wr_first) begin
					pend1_q[wr_idx] <= q_cmd.first;
				end
				if (q_cmd.wr_second) begin
					pend2_q[wr_idx] <= q_cmd.second;
				end
			end
			if (start) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (conn_q[i]) begin
						if (pend1_q[i] != cfg.empty) begin
							pend1_q[i] <= cfg.empty;
						end else begin
							pend2_q[i] <= cfg.empty;
						end
					end
					slot_byte_q[i] <= byte_n[i];
				end
				conn_q[poll_q] <= conn_n;
				type_q[poll_q] <= type_n;
				read_q[poll_q] <= read_n;
				poll_q         <= poll_n;
				busy_q         <= 1'b1;
				beat_q         <= '0;
			end
			if (adv) begin
				beat_q <= beat_q + 1'b1;
				if (last_beat) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame snapshot, checksum accumulator and output payload.
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < SLOTS; i++) begin
				snap_q[i] <= byte_d[i];
			end
			sum_q      <= '0;
			pol_slot_q <= poll_q;
			pol_conn_q <= conn_n;
			pol_type_q <= type_n;
			pol_read_q <= read_n;
		end
		if (adv) begin
			end_q   <= last_beat;
			oslot_q <= pol_slot_q;
			oconn_q <= pol_conn_q;
			otype_q <= pol_type_q;
			oread_q <= pol_read_q;
			if (beat_q == '0) begin
				line_q <= cfg.header;
			end else if (last_beat) begin
				line_q <= fold_check(16'(sum_q), 4'(pol_slot_q));
			end else begin
				line_q <= snap_q[0];
				sum_q  <= sum_q + SUM_W'(snap_q[0]);
				for (int i = 0; i < SLOTS - 1; i++) begin
					snap_q[i] <= snap_q[i + 1];
				end
			end
		end
	end

	assign oslot_ext        = (PW + 2)'(oslot_q);
	assign out_valid        = out_valid_q;
	assign line_byte        = line_q;
	assign frame_end        = end_q;
	assign polled_slot      = oslot_ext[1:0];
	assign polled_connected = oconn_q;
	assign polled_type      = otype_q;
	assign polled_reading   = oread_q;

	// The sequencer goes idle right after the checksum beat is loaded.
	a_idle_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_beat) |=> !busy_q)
		else $error("sequencer still busy after checksum beat");

	// A frame start always leads to the header beat first.
	a_start_header: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && (beat_q == '0)))
		else $error("frame did not begin with header beat");

	// A new frame never starts while one is still being sent.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !(adv && last_beat)) |=> !$past(start) || $past(busy_q) == 1'b0)
		else $error("frame started during another frame");

	// The poll pointer stays inside the slot range.
	a_poll_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(poll_q) < SLOTS)
		else $error("poll pointer out of range");

endmodule
`default_nettype wire

// ===== rtl/smart_module_chain_frame_controller.sv =====
`default_nettype none
// Master side of a daisy-chained module bus, handled one byte per beat.
// Input channel (in_valid/in_ready): each beat is either a write item, which
// queues up to two pending bytes for one slot, or a frame item, which carries
// the reply byte of the slot polled by that frame.
// Output channel (out_valid/out_ready): a frame item gives SLOTS + 2 beats,
// the header byte, one byte per slot and the folded checksum, which is marked
// by frame_end. Write items give no output beats.
// Accepted items pass a short command queue; the back end takes a write on
// reaching the queue head and starts a frame by draining the slots and taking
// the reply, then sends one output beat per cycle while the receiver keeps up;
// at the default of four slots a frame gives six beats. With the queue and the
// back end idle, a frame item passes the queue, the sequencer and the output
// register before its header beat is offered. Writes that follow a frame are
// carried out while its beats still go out; the next frame waits for the
// previous checksum beat. A receiver stall holds the output register and the
// sequencer; the queue keeps taking items until it is full, then in_ready
// falls. Reset clears the queue, the sequencer, the slot state and the poll
// pointer and restores every configuration register to its documented default.
// Configuration is written through cfg_write/cfg_index/cfg_data, one register
// per cycle; an unknown index is ignored. The user must write it only while
// the block is idle; the block leaves this check to the user.
module smart_module_chain_frame_controller #(
	parameter int SLOTS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [scfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       operation,
	input  wire logic [1:0] slot_index,
	input  wire logic [7:0] first_byte,
	input  wire logic       write_first,
	input  wire logic [7:0] second_byte,
	input  wire logic       write_second,
	input  wire logic [7:0] reply_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      line_byte,
	output logic            frame_end,
	output logic [1:0]      polled_slot,
	output logic            polled_connected,
	output logic [7:0]      polled_type,
	output logic [7:0]      polled_reading
);
	import scfc_pkg::*;

	cfg_t cfg_q;
	cmd_t in_cmd;
	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header   <= HEADER_RST;
			cfg_q.empty    <= EMPTY_RST;
			cfg_q.no_mod   <= NO_MOD_RST;
			cfg_q.new_mod  <= NEW_MOD_RST;
			cfg_q.identify <= IDENTIFY_RST;
			cfg_q.servo    <= SERVO_RST;
			cfg_q.lamp     <= LAMP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEADER:   cfg_q.header   <= cfg_data;
				REG_EMPTY:    cfg_q.empty    <= cfg_data;
				REG_NO_MOD:   cfg_q.no_mod   <= cfg_data;
				REG_NEW_MOD:  cfg_q.new_mod  <= cfg_data;
				REG_IDENTIFY: cfg_q.identify <= cfg_data;
				REG_SERVO:    cfg_q.servo    <= cfg_data;
				REG_LAMP:     cfg_q.lamp     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The input beat as one command word.
	assign in_cmd.is_frame  = operation;
	assign in_cmd.slot      = slot_index;
	assign in_cmd.first     = first_byte;
	assign in_cmd.wr_first  = write_first;
	assign in_cmd.second    = second_byte;
	assign in_cmd.wr_second = write_second;
	assign in_cmd.reply     = reply_byte;

	scfc_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (in_cmd),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	scfc_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_cmd            (q_cmd),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.line_byte        (line_byte),
		.frame_end        (frame_end),
		.polled_slot      (polled_slot),
		.polled_connected (polled_connected),
		.polled_type      (polled_type),
		.polled_reading   (polled_reading)
	);

endmodule
`default_nettype wire
